[rtl/core/nqsc_pkg.sv]
package nqsc_pkg;

    localparam int MAX_SIZE = 14;
    localparam int SIZE_W   = 4;
    localparam int COL_W    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int ROW_W    = $clog2(MAX_SIZE + 1);
    localparam int DIAG_W   = 2 * MAX_SIZE - 1;
    localparam int DIAG_IW  = $clog2(DIAG_W);
    localparam int COUNT_W  = 19;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [SIZE_W-1:0]  BOARD_RESET = SIZE_W'(8);

    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef logic [COL_W-1:0] t_col;
    typedef logic [ROW_W-1:0] t_row;

    typedef struct packed {
        logic hit;
        t_row row;
    } t_scan;

    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] total;
        logic               status;
    } t_result;

endpackage

[rtl/core/n_queens_solution_counter.sv]
// N-queens solution counter.
// Config: i_cfg_we writes i_cfg_wdata into the board size register (reset 8).
// Input channel (i_in_valid / o_in_ready) carries one word, i_start_request.
// A word with the start bit low is taken and dropped without a result.
// A word with the start bit high runs a full depth-first search and yields
// one output word (o_out_valid / i_out_ready): solution total and status.
// Status 1 with total 0 means an empty or oversized board; no search runs.
// Each scan step places a queen or counts a full placement; a step back also
// passes through a pop state, since the placed-row stack is a memory with a
// registered read. A search enters from idle and ends in a finish state.
// One search runs at a time; o_in_ready is high only while the engine is idle.
// The result sits in an output register, so the engine returns to idle while
// the word waits; if the receiver stalls with a word held, a finished search
// holds its result until that register frees.
// Reset clears the control state and the output valid; the stack needs no
// clearing since each entry is written before it is read.
module n_queens_solution_counter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [nqsc_pkg::SIZE_W-1:0] i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_start_request,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [nqsc_pkg::COUNT_W-1:0] o_solution_total,
    output logic                        o_search_status
);
    import nqsc_pkg::*;

    logic [SIZE_W-1:0]  r_board_size;
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_total;
    logic               r_out_status;

    logic    idle;
    logic    out_free;
    logic    start;
    t_result result;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = idle;
    assign start      = i_in_valid && idle && i_start_request;

    nqsc_search u_search (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_size     (r_board_size),
        .i_out_free (out_free),
        .o_idle     (idle),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_size <= BOARD_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_board_size <= i_cfg_wdata;
            end
            if (result.valid && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (result.valid && out_free) begin
            r_out_total  <= result.total;
            r_out_status <= result.status;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_solution_total = r_out_total;
    assign o_search_status  = r_out_status;

endmodule

[rtl/core/nqsc_stack_ram.sv]
module nqsc_stack_ram (
    input  logic          i_clk,
    input  logic          i_we,
    input  nqsc_pkg::t_col i_waddr,
    input  nqsc_pkg::t_row i_wdata,
    input  nqsc_pkg::t_col i_raddr,
    output nqsc_pkg::t_row o_rdata
);
    import nqsc_pkg::*;

    t_row r_mem [MAX_SIZE];
    t_row r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/nqsc_free_scan.sv]
module nqsc_free_scan (
    input  logic [nqsc_pkg::MAX_SIZE-1:0] i_row_mask,
    input  logic [nqsc_pkg::DIAG_W-1:0]   i_rise_mask,
    input  logic [nqsc_pkg::DIAG_W-1:0]   i_fall_mask,
    input  nqsc_pkg::t_col                i_col,
    input  logic [nqsc_pkg::SIZE_W-1:0]   i_size,
    input  nqsc_pkg::t_row                i_row_start,
    output nqsc_pkg::t_scan               o_scan
);
    import nqsc_pkg::*;

    logic [DIAG_IW-1:0]  fall_off;
    logic [DIAG_W-1:0]   rise_sh;
    logic [DIAG_W-1:0]   fall_sh;
    logic [MAX_SIZE-1:0] avail;

    // align both diagonal masks so that bit r belongs to row r of this column
    always_comb begin
        fall_off = DIAG_IW'(i_size) - DIAG_IW'(1) - DIAG_IW'(i_col);
        rise_sh  = i_rise_mask >> i_col;
        fall_sh  = i_fall_mask >> fall_off;
        for (int r = 0; r < MAX_SIZE; r++) begin
            avail[r] = !i_row_mask[r] && !rise_sh[r] && !fall_sh[r]
                       && (r >= int'(i_row_start)) && (r < int'(i_size));
        end
    end

    // lowest free row at or above the start row
    always_comb begin
        o_scan.hit = |avail;
        o_scan.row = '0;
        for (int r = MAX_SIZE - 1; r >= 0; r--) begin
            if (avail[r]) begin
                o_scan.row = ROW_W'(r);
            end
        end
    end

endmodule

[rtl/core/nqsc_search.sv]
module nqsc_search (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [nqsc_pkg::SIZE_W-1:0] i_size,
    input  logic                        i_out_free,
    output logic                        o_idle,
    output nqsc_pkg::t_result           o_result
);
    import nqsc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]          r_state,     n_state;
    logic [SIZE_W-1:0]   r_size,      n_size;
    t_col                r_col,       n_col;
    t_row                r_row,       n_row;
    logic [MAX_SIZE-1:0] r_row_mask,  n_row_mask;
    logic [DIAG_W-1:0]   r_rise_mask, n_rise_mask;
    logic [DIAG_W-1:0]   r_fall_mask, n_fall_mask;
    logic [COUNT_W-1:0]  r_count,     n_count;
    logic                r_status,    n_status;

    t_scan              scan;
    logic               ram_we;
    t_col               ram_raddr;
    t_row               ram_rdata;
    logic               tog_en;
    t_row               tog_row;
    logic [DIAG_IW-1:0] rise_idx;
    logic [DIAG_IW-1:0] fall_idx;

    nqsc_free_scan u_scan (
        .i_row_mask  (r_row_mask),
        .i_rise_mask (r_rise_mask),
        .i_fall_mask (r_fall_mask),
        .i_col       (r_col),
        .i_size      (r_size),
        .i_row_start (r_row),
        .o_scan      (scan)
    );

    nqsc_stack_ram u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_col),
        .i_wdata (scan.row),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ram_raddr = r_col - t_col'(1);
    assign tog_row   = (r_state == S_POP) ? ram_rdata : scan.row;
    assign rise_idx  = DIAG_IW'(tog_row) + DIAG_IW'(r_col);
    assign fall_idx  = DIAG_IW'(tog_row) + DIAG_IW'(r_size) - DIAG_IW'(1) - DIAG_IW'(r_col);

    always_comb begin
        n_state     = r_state;
        n_size      = r_size;
        n_col       = r_col;
        n_row       = r_row;
        n_row_mask  = r_row_mask;
        n_rise_mask = r_rise_mask;
        n_fall_mask = r_fall_mask;
        n_count     = r_count;
        n_status    = r_status;
        ram_we      = 1'b0;
        tog_en      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_size      = i_size;
                    n_col       = '0;
                    n_row       = '0;
                    n_row_mask  = '0;
                    n_rise_mask = '0;
                    n_fall_mask = '0;
                    n_count     = '0;
                    if (i_size == '0 || int'(i_size) > MAX_SIZE) begin
                        n_status = STATUS_EMPTY;
                        n_state  = S_FIN;
                    end else begin
                        n_status = STATUS_DONE;
                        n_state  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (scan.hit) begin
                    if (SIZE_W'(r_col) + SIZE_W'(1) == r_size) begin
                        if (r_count != COUNT_MAX) begin
                            n_count = r_count + COUNT_W'(1);
                        end
                        n_row = scan.row + t_row'(1);
                    end else begin
                        ram_we = 1'b1;
                        tog_en = 1'b1;
                        n_col  = r_col + t_col'(1);
                        n_row  = '0;
                    end
                end else if (r_col == '0) begin
                    n_state = S_FIN;
                end else begin
                    // fetch the row placed one column back
                    n_col   = r_col - t_col'(1);
                    n_state = S_POP;
                end
            end
            S_POP: begin
                tog_en  = 1'b1;
                n_row   = ram_rdata + t_row'(1);
                n_state = S_SCAN;
            end
            S_FIN: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (tog_en) begin
            n_row_mask  = r_row_mask ^ (MAX_SIZE'(1) << tog_row);
            n_rise_mask = r_rise_mask ^ (DIAG_W'(1) << rise_idx);
            n_fall_mask = r_fall_mask ^ (DIAG_W'(1) << fall_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row_mask  <= '0;
            r_rise_mask <= '0;
            r_fall_mask <= '0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row_mask  <= n_row_mask;
            r_rise_mask <= n_rise_mask;
            r_fall_mask <= n_fall_mask;
            r_count     <= n_count;
        end
        r_size   <= n_size;
        r_row    <= n_row;
        r_status <= n_status;
    end

    assign o_idle          = (r_state == S_IDLE);
    assign o_result.valid  = (r_state == S_FIN);
    assign o_result.total  = r_count;
    assign o_result.status = r_status;

endmodule
